FILE: rtl/mrsv_pkg.sv
// Package for the MIDI running-status volume parser.
// Holds the buffer size, status codes, length tables and the item and event types.
// Depends on nothing.
package mrsv_pkg;

    localparam int MESSAGE_BUFFER_BYTES = 256;
    localparam int BYTE_INDEX_W = $clog2(MESSAGE_BUFFER_BYTES + 1);
    localparam int SYSEX_LENGTH_W = 9;

    localparam logic [7:0] REALTIME_FIRST = 8'hf8;
    localparam logic [7:0] SYSTEM_FIRST = 8'hf0;
    localparam logic [7:0] SYSEX_OPEN = 8'hf0;
    localparam logic [7:0] SYSEX_CLOSE = 8'hf7;
    localparam logic [3:0] CONTROL_CHANGE = 4'hb;
    localparam logic [6:0] VOLUME_CONTROLLER = 7'd7;

    localparam logic EVENT_VOLUME = 1'b0;
    localparam logic EVENT_SYSEX = 1'b1;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       chunk_start;
    } mrsv_item_t;

    typedef struct packed {
        logic                      event_kind;
        logic [3:0]                channel;
        logic [6:0]                volume;
        logic [SYSEX_LENGTH_W-1:0] sysex_length;
    } mrsv_event_t;

    function automatic logic [1:0] voice_length(input logic [2:0] idx);
        logic [1:0] len;
        case (idx)
            3'd0: len = 2'd3;
            3'd1: len = 2'd3;
            3'd2: len = 2'd3;
            3'd3: len = 2'd3;
            3'd4: len = 2'd2;
            3'd5: len = 2'd2;
            3'd6: len = 2'd3;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] common_length(input logic [2:0] idx);
        logic [1:0] len;
        case (idx)
            3'd0: len = 2'd0;
            3'd1: len = 2'd2;
            3'd2: len = 2'd3;
            3'd3: len = 2'd2;
            3'd4: len = 2'd0;
            3'd5: len = 2'd0;
            3'd6: len = 2'd1;
            default: len = 2'd1;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/mrsv_in_stage.sv
// Input register of the MIDI parser: holds one accepted byte and its chunk flag.
// Depends on mrsv_pkg.
module mrsv_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mrsv_pkg::mrsv_item_t in_item,
    input  logic               advance,
    output logic               item_valid,
    output mrsv_pkg::mrsv_item_t item
);
    import mrsv_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    mrsv_item_t  item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

FILE: rtl/mrsv_core.sv
// Parser state and the per-byte decode of running status, data counting and events.
// Depends on mrsv_pkg.
module mrsv_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mrsv_pkg::mrsv_item_t item,
    output logic                evt_valid,
    output mrsv_pkg::mrsv_event_t evt
);
    import mrsv_pkg::*;

    logic [7:0]              running_status_reg;
    logic [7:0]              running_status_next;
    logic [1:0]              expected_length_reg;
    logic [1:0]              expected_length_next;
    logic [BYTE_INDEX_W-1:0] byte_index_reg;
    logic [BYTE_INDEX_W-1:0] byte_index_next;
    logic [6:0]              first_data_byte_reg;
    logic [6:0]              first_data_byte_next;

    logic [7:0]              rs;
    logic [1:0]              el;
    logic [BYTE_INDEX_W-1:0] bi;
    logic [6:0]              fdb;
    logic [BYTE_INDEX_W-1:0] bi_base;
    logic [BYTE_INDEX_W-1:0] bi_inc;
    logic [BYTE_INDEX_W+SYSEX_LENGTH_W-1:0] len_ext;
    logic [7:0]              b;

    assign b = item.midi_byte;

    always_comb
    begin
        if (item.chunk_start)
        begin
            rs  = '0;
            el  = '0;
            bi  = '0;
            fdb = '0;
        end
        else
        begin
            rs  = running_status_reg;
            el  = expected_length_reg;
            bi  = byte_index_reg;
            fdb = first_data_byte_reg;
        end
    end

    assign bi_base = (bi == '0) ? BYTE_INDEX_W'(1) : bi;
    assign bi_inc = bi_base + BYTE_INDEX_W'(1);
    assign len_ext = {{SYSEX_LENGTH_W{1'b0}}, bi + BYTE_INDEX_W'(1)};

    always_comb
    begin
        running_status_next  = rs;
        expected_length_next = el;
        byte_index_next      = bi;
        first_data_byte_next = fdb;
        evt_valid            = 1'b0;
        evt.event_kind       = EVENT_VOLUME;
        evt.channel          = '0;
        evt.volume           = '0;
        evt.sysex_length     = '0;
        if (b >= REALTIME_FIRST)
        begin
            evt_valid = 1'b0;
        end
        else if (b >= SYSTEM_FIRST)
        begin
            if (rs == SYSEX_OPEN && b == SYSEX_CLOSE
                && bi < BYTE_INDEX_W'(MESSAGE_BUFFER_BYTES))
            begin
                byte_index_next  = bi + BYTE_INDEX_W'(1);
                evt_valid        = 1'b1;
                evt.event_kind   = EVENT_SYSEX;
                evt.sysex_length = len_ext[SYSEX_LENGTH_W-1:0];
            end
            else
            begin
                running_status_next  = b;
                expected_length_next = common_length(b[2:0]);
                byte_index_next      = BYTE_INDEX_W'(1);
            end
        end
        else if (b[7])
        begin
            running_status_next  = b;
            expected_length_next = voice_length(b[6:4]);
            byte_index_next      = BYTE_INDEX_W'(1);
        end
        else if (rs != '0 && bi < BYTE_INDEX_W'(MESSAGE_BUFFER_BYTES))
        begin
            if (bi_base == BYTE_INDEX_W'(1))
            begin
                first_data_byte_next = b[6:0];
            end
            if (bi_inc == BYTE_INDEX_W'(el))
            begin
                byte_index_next = '0;
                if (rs[7:4] == CONTROL_CHANGE && first_data_byte_next == VOLUME_CONTROLLER)
                begin
                    evt_valid      = 1'b1;
                    evt.event_kind = EVENT_VOLUME;
                    evt.channel    = rs[3:0];
                    evt.volume     = b[6:0];
                end
            end
            else
            begin
                byte_index_next = bi_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_status_reg  <= '0;
            expected_length_reg <= '0;
            byte_index_reg      <= '0;
            first_data_byte_reg <= '0;
        end
        else if (step)
        begin
            running_status_reg  <= running_status_next;
            expected_length_reg <= expected_length_next;
            byte_index_reg      <= byte_index_next;
            first_data_byte_reg <= first_data_byte_next;
        end
    end

endmodule

FILE: rtl/mrsv_out_stage.sv
// Result register of the MIDI parser: holds one event until the receiver takes it.
// Depends on mrsv_pkg.
module mrsv_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 evt_valid,
    input  mrsv_pkg::mrsv_event_t evt,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 free,
    output mrsv_pkg::mrsv_event_t result
);
    import mrsv_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    mrsv_event_t  result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = evt_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && evt_valid)
        begin
            result_reg <= evt;
        end
    end

    assign out_valid = valid_reg;
    assign result = result_reg;

endmodule

FILE: rtl/midi_running_status_volume_parser.sv
// Top level of the MIDI running-status parser with volume and sysex-end events.
// Depends on mrsv_pkg, mrsv_in_stage, mrsv_core and mrsv_out_stage.
//
// The input channel carries one MIDI byte per transfer with a chunk_start flag
// that clears the parser state before that byte. The output channel carries one
// event per transfer: a channel volume update or a completed sysex with its length.
// Bytes that cause no event produce no output transfer.
// A byte is taken into an input register, decoded against the parser state, and its
// event is loaded into the result register, which raises out_valid; the result
// register takes an event only when it is empty or its event is being taken.
// One byte per cycle is sustained while the receiver is ready; the single decode
// step between the input and result registers sets that figure.
// Reset clears the parser state and both valid flags. When the receiver stalls, the
// result register holds its event, the byte in the input register waits, and
// in_ready stays high only while the input register is empty.
module midi_running_status_volume_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          midi_byte,
    input  logic                                chunk_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                event_kind,
    output logic [3:0]                          channel,
    output logic [6:0]                          volume,
    output logic [mrsv_pkg::SYSEX_LENGTH_W-1:0] sysex_length
);
    import mrsv_pkg::*;

    mrsv_item_t  in_item;
    mrsv_item_t  item;
    logic        item_valid;
    logic        advance;
    logic        out_free;
    logic        evt_valid;
    mrsv_event_t evt;
    mrsv_event_t result;

    assign in_item.midi_byte = midi_byte;
    assign in_item.chunk_start = chunk_start;
    assign advance = item_valid && out_free;

    mrsv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mrsv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item),
        .evt_valid (evt_valid),
        .evt       (evt)
    );

    mrsv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .evt_valid (evt_valid),
        .evt       (evt),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .free      (out_free),
        .result    (result)
    );

    assign event_kind = result.event_kind;
    assign channel = result.channel;
    assign volume = result.volume;
    assign sysex_length = result.sysex_length;

endmodule

FILE: tb/tb_midi_running_status_volume_parser.sv
// Self-checking testbench for midi_running_status_volume_parser.
// Drives directed rows, buffer and hold-off tests, random streams; checks events vs a model.
// Depends on mrsv_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_midi_running_status_volume_parser;
    import mrsv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 250;
    localparam int DIR_N = 25;

    localparam logic [7:0] NO_STATUS = 8'h00;
    localparam logic [7:0] RT_LAST = 8'hff;
    localparam logic [7:0] VOICE_FIRST = 8'h80;
    localparam logic [7:0] VOICE_LAST = 8'hef;
    localparam logic [7:0] COMMON_FIRST = 8'hf1;
    localparam logic [7:0] COMMON_LAST = 8'hf6;
    localparam logic [7:0] UNDEFINED_COMMON = 8'hf4;
    localparam logic [3:0] PROGRAM_CHANGE = 4'hc;

    typedef struct packed {
        logic [7:0]  midi_byte;
        logic        chunk_start;
        logic        typed;
        logic        has_event;
        mrsv_event_t ev;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] midi_byte = 8'h00;
    logic       chunk_start = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       event_kind;
    logic [3:0] channel;
    logic [6:0] volume;
    logic [SYSEX_LENGTH_W-1:0] sysex_length;

    logic [7:0]  ps_status = NO_STATUS;
    logic [1:0]  ps_len = 2'd0;
    int unsigned ps_count = 0;
    logic [6:0]  ps_first = 7'd0;

    logic [1:0] voice_len_tab [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd0};
    logic [1:0] common_len_tab [8] = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};

    mrsv_event_t pending_events [$];
    dir_row_t    dir_rows [DIR_N];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned stream_items = 0;
    int unsigned volume_seen = 0;
    int unsigned sysex_seen = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    midi_running_status_volume_parser uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .midi_byte(midi_byte),
        .chunk_start(chunk_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_kind(event_kind),
        .channel(channel),
        .volume(volume),
        .sysex_length(sysex_length)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic mrsv_event_t vol_ev(input logic [3:0] ch, input logic [6:0] v);
        mrsv_event_t ev;
        ev = '0;
        ev.event_kind = EVENT_VOLUME;
        ev.channel = ch;
        ev.volume = v;
        return ev;
    endfunction

    function automatic mrsv_event_t sysex_ev(input logic [SYSEX_LENGTH_W-1:0] len);
        mrsv_event_t ev;
        ev = '0;
        ev.event_kind = EVENT_SYSEX;
        ev.sysex_length = len;
        return ev;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic cs,
                                      output mrsv_event_t ev);
        ev = '0;
        if (cs)
        begin
            ps_status = NO_STATUS;
            ps_len = 2'd0;
            ps_count = 0;
            ps_first = 7'd0;
        end
        if (b >= REALTIME_FIRST)
            return 1'b0;
        if (b >= SYSTEM_FIRST)
        begin
            if (ps_status == SYSEX_OPEN && b == SYSEX_CLOSE &&
                ps_count < MESSAGE_BUFFER_BYTES)
            begin
                ps_count++;
                ev = sysex_ev(ps_count[SYSEX_LENGTH_W-1:0]);
                return 1'b1;
            end
            ps_status = b;
            ps_len = common_len_tab[b[2:0]];
            ps_count = 1;
            return 1'b0;
        end
        if (b[7])
        begin
            ps_status = b;
            ps_len = voice_len_tab[b[6:4]];
            ps_count = 1;
            return 1'b0;
        end
        if (ps_status == NO_STATUS || ps_count >= MESSAGE_BUFFER_BYTES)
            return 1'b0;
        if (ps_count == 0)
            ps_count = 1;
        if (ps_count == 1)
            ps_first = b[6:0];
        ps_count++;
        if (ps_count == ps_len)
        begin
            ps_count = 0;
            if (ps_status[7:4] == CONTROL_CHANGE && ps_first == VOLUME_CONTROLLER)
            begin
                ev = vol_ev(ps_status[3:0], b[6:0]);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back transfers.
    task automatic transfer_byte(input logic [7:0] b, input logic cs,
                                 input bit use_model = 1'b1);
        mrsv_event_t ev;
        bit          has_event;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        midi_byte = b;
        chunk_start = cs;
        do
            @(posedge clk);
        while (!in_ready);
        has_event = parse_byte(b, cs, ev);
        if (use_model && has_event)
            pending_events.push_back(ev);
        if (b < REALTIME_FIRST)
            stream_items++;
        @(negedge clk);
    endtask

    task automatic msg_byte(input logic [7:0] b);
        if ($urandom_range(99) < 6)
            transfer_byte(8'($urandom_range(REALTIME_FIRST, RT_LAST)), 1'b0);
        transfer_byte(b, $urandom_range(99) < 2);
    endtask

    task automatic send_message();
        int         kind;
        logic [3:0] ch;
        kind = $urandom_range(99);
        ch = 4'($urandom_range(15));
        if (kind < 50)
        begin
            if ($urandom_range(2) != 0)
                msg_byte({CONTROL_CHANGE, ch});
            msg_byte(kind < 35 ? {1'b0, VOLUME_CONTROLLER} : 8'($urandom_range(127)));
            msg_byte(8'($urandom_range(127)));
        end
        else if (kind < 62)
        begin
            msg_byte(8'($urandom_range(VOICE_FIRST, VOICE_LAST)));
            repeat ($urandom_range(1, 2)) msg_byte(8'($urandom_range(127)));
        end
        else if (kind < 74)
        begin
            msg_byte(SYSEX_OPEN);
            repeat ($urandom_range(12)) msg_byte(8'($urandom_range(127)));
            msg_byte(SYSEX_CLOSE);
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(3)) msg_byte(8'($urandom_range(127)));
                msg_byte(SYSEX_CLOSE);
            end
        end
        else if (kind < 82)
        begin
            msg_byte(8'($urandom_range(COMMON_FIRST, COMMON_LAST)));
            repeat ($urandom_range(2)) msg_byte(8'($urandom_range(127)));
        end
        else
            transfer_byte(8'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void note_mismatch(input string what, input mrsv_event_t want,
                                          input mrsv_event_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $time, what, want.event_kind, want.channel, want.volume,
                     want.sysex_length, got.event_kind, got.channel, got.volume,
                     got.sysex_length);
    endfunction

    always @(posedge clk)
    begin
        mrsv_event_t got;
        mrsv_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {event_kind, channel, volume, sysex_length};
            if (got.event_kind == EVENT_SYSEX)
                sysex_seen++;
            else
                volume_seen++;
            if (pending_events.size() == 0)
                note_mismatch("unexpected event", '0, got);
            else
            begin
                want = pending_events.pop_front();
                if (got !== want)
                    note_mismatch("event mismatch", want, got);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d events outstanding.",
                     cycle_count, pending_events.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned src_mix [4];
        int unsigned sink_mix [4];
        int unsigned target;
        src_mix = '{0, 74, 0, 18};
        sink_mix = '{0, 0, 74, 18};
        dir_rows = '{
            '{NO_STATUS, 1'b1, 1'b1, 1'b0, '0},
            '{{CONTROL_CHANGE, 4'h5}, 1'b0, 1'b1, 1'b0, '0},
            '{{1'b0, VOLUME_CONTROLLER}, 1'b0, 1'b1, 1'b0, '0},
            '{8'h7f, 1'b0, 1'b1, 1'b1, vol_ev(4'h5, 7'd127)},
            '{{1'b0, VOLUME_CONTROLLER}, 1'b0, 1'b1, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, 1'b1, vol_ev(4'h5, 7'd0)},
            '{RT_LAST, 1'b0, 1'b1, 1'b0, '0},
            '{{CONTROL_CHANGE, 4'hf}, 1'b0, 1'b1, 1'b0, '0},
            '{{1'b0, VOLUME_CONTROLLER}, 1'b0, 1'b1, 1'b0, '0},
            '{REALTIME_FIRST, 1'b0, 1'b1, 1'b0, '0},
            '{8'h40, 1'b0, 1'b1, 1'b1, vol_ev(4'hf, 7'd64)},
            '{{CONTROL_CHANGE, 4'h0}, 1'b0, 1'b0, 1'b0, '0},
            '{8'h0a, 1'b0, 1'b0, 1'b0, '0},
            '{8'h40, 1'b0, 1'b0, 1'b0, '0},
            '{SYSEX_OPEN, 1'b0, 1'b1, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 1'b0, '0},
            '{8'h7f, 1'b0, 1'b0, 1'b0, '0},
            '{SYSEX_CLOSE, 1'b0, 1'b1, 1'b1, sysex_ev(9'd4)},
            '{8'h12, 1'b0, 1'b0, 1'b0, '0},
            '{SYSEX_CLOSE, 1'b0, 1'b1, 1'b1, sysex_ev(9'd6)},
            '{UNDEFINED_COMMON, 1'b0, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b0, 1'b0, '0},
            '{{PROGRAM_CHANGE, 4'h3}, 1'b1, 1'b0, 1'b0, '0},
            '{{1'b0, VOLUME_CONTROLLER}, 1'b0, 1'b0, 1'b0, '0},
            '{SYSEX_CLOSE, 1'b1, 1'b1, 1'b0, '0}
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            transfer_byte(dir_rows[i].midi_byte, dir_rows[i].chunk_start, !dir_rows[i].typed);
            if (dir_rows[i].typed && dir_rows[i].has_event)
                pending_events.push_back(dir_rows[i].ev);
        end
        wait_drained();

        // Fill the sysex buffer exactly, then overrun it by one byte.
        transfer_byte(SYSEX_OPEN, 1'b1);
        repeat (MESSAGE_BUFFER_BYTES - 2) transfer_byte(8'($urandom_range(127)), 1'b0);
        transfer_byte(SYSEX_CLOSE, 1'b0);
        transfer_byte(8'($urandom_range(127)), 1'b0);
        transfer_byte(SYSEX_CLOSE, 1'b0);
        transfer_byte({1'b0, VOLUME_CONTROLLER}, 1'b0);
        wait_drained();

        // The receiver holds off while volume updates keep arriving back to back.
        hold_seq <= hold_seq + 1;
        repeat (40)
        begin
            transfer_byte({CONTROL_CHANGE, 4'($urandom_range(15))}, 1'b0);
            transfer_byte({1'b0, VOLUME_CONTROLLER}, 1'b0);
            transfer_byte(8'($urandom_range(127)), 1'b0);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = src_mix[ph];
            sink_stall_pct <= sink_mix[ph];
            target = stream_items + PHASE_ITEMS;
            while (stream_items < target)
                send_message();
            wait_drained();
        end

        $display("Streamed %0d non-real-time bytes; checked %0d volume and %0d sysex events.",
                 stream_items, volume_seen, sysex_seen);
        $display("Covered a full sysex buffer, a long receiver hold-off and four idle mixes.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
